@@ rtl/qapm_pkg.sv @@
`default_nettype none

package qapm_pkg;

   // Field and datapath widths.
   localparam int QuatW    = 16;
   localparam int RateErrW = 17;
   localparam int ErrW     = 34;
   localparam int MagW     = 31;
   localparam int SumW     = 64;
   localparam int NormW    = SumW / 2;
   localparam int NvW      = 15;
   localparam int TauW     = 28;
   localparam int ForceW   = 48;
   localparam int SpeedSqW = 46;
   localparam int RootW    = SpeedSqW / 2;
   localparam int SpeedW   = 16;
   localparam int CsrIndexW = 3;
   localparam int CsrDataW  = 48;

   // sqrt(2) in Q1.16 for the X frame mixing.
   localparam logic [16:0] Sqrt2Q16 = 17'd92682;

   // Configuration register indexes.
   typedef enum logic [CsrIndexW-1:0] {
      CSR_KP       = 3'd0,
      CSR_KD       = 3'd1,
      CSR_FLIGHT   = 3'd2,
      CSR_ARM      = 3'd3,
      CSR_YAW      = 3'd4,
      CSR_THRUST   = 3'd5,
      CSR_DEADBAND = 3'd6
   } csr_index_type;

   typedef enum logic {
      FRAME_PLUS = 1'b0,
      FRAME_X    = 1'b1
   } frame_type;

   typedef struct packed {
      logic [47:0] kp;
      logic [47:0] kd;
      frame_type   frame;
      logic [15:0] arm_recip;
      logic [15:0] yaw_recip;
      logic [31:0] thrust_recip;
      logic [7:0]  deadband;
   } cfg_type;

   localparam cfg_type CfgReset = '{
      kp:           48'h1333_1000_1000,
      kd:           48'h0266_019A_019A,
      frame:        FRAME_PLUS,
      arm_recip:    16'd256,
      yaw_recip:    16'd256,
      thrust_recip: 32'd65536,
      deadband:     8'd7
   };

   typedef struct packed {
      logic [15:0] thrust;
      logic [47:0] des_rates;
      logic [47:0] meas_rates;
      logic [63:0] des_quat;
      logic [63:0] meas_quat;
   } req_type;

   typedef struct packed {
      logic [3:0]        clamp_flags;
      logic [SpeedW-1:0] motor_speed_3;
      logic [SpeedW-1:0] motor_speed_2;
      logic [SpeedW-1:0] motor_speed_1;
      logic [SpeedW-1:0] motor_speed_0;
   } rsp_type;

   // Per-item context that rides alongside the norm and divide pipelines.
   typedef struct packed {
      logic                         sgn_neg;
      logic [2:0]                   vec_neg;
      logic [2:0][RateErrW-1:0]     rate_err;
      logic [15:0]                  thrust;
   } ctx_type;

   typedef struct packed {
      ctx_type              ctx;
      logic [2:0][MagW-1:0] mag;
   } sqrt_side_type;

endpackage

`default_nettype wire

@@ rtl/qapm_isqrt.sv @@
`default_nettype none

module qapm_isqrt #(
   parameter int InW   = 64,
   parameter int Lanes = 1,
   parameter int SideW = 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic [Lanes-1:0][InW-1:0]      in_value,
   input  logic [SideW-1:0]               in_side,
   output logic                           out_valid,
   output logic [Lanes-1:0][InW/2-1:0]    out_root,
   output logic [SideW-1:0]               out_side
);

   localparam int OutW = InW / 2;
   localparam int RemW = OutW + 3;

   logic                         valid_ff [OutW];
   logic [Lanes-1:0][InW-1:0]    val_ff   [OutW];
   logic [Lanes-1:0][RemW-1:0]   rem_ff   [OutW];
   logic [Lanes-1:0][OutW-1:0]   root_ff  [OutW];
   logic [SideW-1:0]             side_ff  [OutW];

   // One root bit per stage, two radicand bits consumed per stage.
   for (genvar s = 0; s < OutW; s++) begin : g_stage
      logic                         src_valid;
      logic [Lanes-1:0][InW-1:0]    src_val;
      logic [Lanes-1:0][RemW-1:0]   src_rem;
      logic [Lanes-1:0][OutW-1:0]   src_root;
      logic [SideW-1:0]             src_side;
      logic [Lanes-1:0][InW-1:0]    val_in;
      logic [Lanes-1:0][RemW-1:0]   rem_in;
      logic [Lanes-1:0][OutW-1:0]   root_in;

      if (s == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_val   = in_value;
         assign src_rem   = '0;
         assign src_root  = '0;
         assign src_side  = in_side;
      end else begin : g_next
         assign src_valid = valid_ff[s-1];
         assign src_val   = val_ff[s-1];
         assign src_rem   = rem_ff[s-1];
         assign src_root  = root_ff[s-1];
         assign src_side  = side_ff[s-1];
      end

      // Trial subtract of 4*root+1 from the shifted remainder.
      always_comb begin
         logic [RemW-1:0] shifted;
         logic [RemW-1:0] trial;
         for (int l = 0; l < Lanes; l++) begin
            shifted = {src_rem[l][RemW-3:0], src_val[l][InW-1 -: 2]};
            trial   = {1'b0, src_root[l], 2'b01};
            if (shifted >= trial) begin
               rem_in[l]  = shifted - trial;
               root_in[l] = {src_root[l][OutW-2:0], 1'b1};
            end else begin
               rem_in[l]  = shifted;
               root_in[l] = {src_root[l][OutW-2:0], 1'b0};
            end
            val_in[l] = {src_val[l][InW-3:0], 2'b00};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= src_valid;
         end
         val_ff[s]  <= val_in;
         rem_ff[s]  <= rem_in;
         root_ff[s] <= root_in;
         side_ff[s] <= src_side;
      end
   end

   assign out_valid = valid_ff[OutW-1];
   assign out_root  = root_ff[OutW-1];
   assign out_side  = side_ff[OutW-1];

endmodule

`default_nettype wire

@@ rtl/qapm_div.sv @@
`default_nettype none

module qapm_div #(
   parameter int QuotW = 15,
   parameter int NumW  = 31,
   parameter int DenW  = 32,
   parameter int Lanes = 3,
   parameter int SideW = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [Lanes-1:0][NumW-1:0]    in_num,
   input  logic [DenW-1:0]               in_den,
   input  logic [SideW-1:0]              in_side,
   output logic                          out_valid,
   output logic [Lanes-1:0][QuotW-1:0]   out_quot,
   output logic [SideW-1:0]              out_side
);

   localparam int RemW = DenW + 1;

   logic                          valid_ff [QuotW];
   logic [Lanes-1:0][RemW-1:0]    rem_ff   [QuotW];
   logic [Lanes-1:0][QuotW-1:0]   quot_ff  [QuotW];
   logic [DenW-1:0]               den_ff   [QuotW];
   logic [SideW-1:0]              side_ff  [QuotW];

   // Restoring division, one quotient bit per stage. The numerator never
   // exceeds the divisor, so the first stage yields the integer bit.
   for (genvar s = 0; s < QuotW; s++) begin : g_stage
      logic                          src_valid;
      logic [Lanes-1:0][RemW-1:0]    src_rem;
      logic [Lanes-1:0][QuotW-1:0]   src_quot;
      logic [DenW-1:0]               src_den;
      logic [SideW-1:0]              src_side;
      logic [Lanes-1:0][RemW-1:0]    rem_in;
      logic [Lanes-1:0][QuotW-1:0]   quot_in;

      if (s == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_quot  = '0;
         assign src_den   = in_den;
         assign src_side  = in_side;
         for (genvar l = 0; l < Lanes; l++) begin : g_lane
            assign src_rem[l] = RemW'(in_num[l]);
         end
      end else begin : g_next
         assign src_valid = valid_ff[s-1];
         assign src_rem   = rem_ff[s-1];
         assign src_quot  = quot_ff[s-1];
         assign src_den   = den_ff[s-1];
         assign src_side  = side_ff[s-1];
      end

      // A zero divisor only occurs with zero numerators; it yields zero.
      always_comb begin
         logic [RemW-1:0] shifted;
         for (int l = 0; l < Lanes; l++) begin
            shifted = (s == 0) ? src_rem[l] : {src_rem[l][RemW-2:0], 1'b0};
            if ((src_den != '0) && (shifted >= RemW'(src_den))) begin
               rem_in[l]  = shifted - RemW'(src_den);
               quot_in[l] = {src_quot[l][QuotW-2:0], 1'b1};
            end else begin
               rem_in[l]  = shifted;
               quot_in[l] = {src_quot[l][QuotW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= src_valid;
         end
         rem_ff[s]  <= rem_in;
         quot_ff[s] <= quot_in;
         den_ff[s]  <= src_den;
         side_ff[s] <= src_side;
      end
   end

   assign out_valid = valid_ff[QuotW-1];
   assign out_quot  = quot_ff[QuotW-1];
   assign out_side  = side_ff[QuotW-1];

endmodule

`default_nettype wire

@@ rtl/qapm_err.sv @@
`default_nettype none

module qapm_err (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   input  qapm_pkg::req_type                    in_req,
   output logic                                 out_valid,
   output logic [0:0][qapm_pkg::SumW-1:0]       out_sum,
   output qapm_pkg::sqrt_side_type              out_side
);

   import qapm_pkg::*;

   localparam int ProdW = 2 * QuatW;
   localparam int SqW   = 2 * MagW;

   logic                     v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic signed [ProdW-1:0]  prod_ff [4][4];
   logic signed [ProdW-1:0]  prod_in [4][4];
   ctx_type                  ctx1_ff, ctx1_in, ctx2_ff, ctx3_ff, ctx3_in, ctx4_ff;
   logic signed [ErrW-1:0]   err_ff [4];
   logic signed [ErrW-1:0]   err_in [4];
   logic [MagW-1:0]          mag_ff [4];
   logic [MagW-1:0]          mag_in [4];
   logic [SqW-1:0]           sq_ff [4];
   logic [SqW-1:0]           sq_in [4];
   logic [2:0][MagW-1:0]     mag4_ff;
   logic [SumW-1:0]          sum_ff, sum_in;
   sqrt_side_type            side5_ff, side5_in;

   // Stage 1: all sixteen component products, and the rate error.
   always_comb begin
      logic signed [QuatW-1:0] qv [4];
      logic signed [QuatW-1:0] dv [4];
      for (int a = 0; a < 4; a++) begin
         qv[a] = $signed(in_req.meas_quat[QuatW*a +: QuatW]);
         dv[a] = $signed(in_req.des_quat[QuatW*a +: QuatW]);
      end
      for (int a = 0; a < 4; a++) begin
         for (int b = 0; b < 4; b++) begin
            prod_in[a][b] = qv[a] * dv[b];
         end
      end
      ctx1_in = '0;
      ctx1_in.thrust = in_req.thrust;
      for (int i = 0; i < 3; i++) begin
         ctx1_in.rate_err[i] = RateErrW'($signed(in_req.des_rates[16*i +: 16]))
                             - RateErrW'($signed(in_req.meas_rates[16*i +: 16]));
      end
   end

   // Stage 2: error quaternion conj(q) * qd.
   always_comb begin
      err_in[0] = ErrW'(prod_ff[0][0]) + ErrW'(prod_ff[1][1])
                + ErrW'(prod_ff[2][2]) + ErrW'(prod_ff[3][3]);
      err_in[1] = ErrW'(prod_ff[0][1]) - ErrW'(prod_ff[1][0])
                - ErrW'(prod_ff[2][3]) + ErrW'(prod_ff[3][2]);
      err_in[2] = ErrW'(prod_ff[0][2]) - ErrW'(prod_ff[2][0])
                - ErrW'(prod_ff[3][1]) + ErrW'(prod_ff[1][3]);
      err_in[3] = ErrW'(prod_ff[0][3]) - ErrW'(prod_ff[3][0])
                - ErrW'(prod_ff[1][2]) + ErrW'(prod_ff[2][1]);
   end

   // Stage 3: magnitudes shifted down by two, and the signs.
   always_comb begin
      logic [ErrW-1:0] abs_e;
      ctx3_in = ctx2_ff;
      for (int i = 0; i < 4; i++) begin
         abs_e     = err_ff[i][ErrW-1] ? -err_ff[i] : err_ff[i];
         mag_in[i] = abs_e[ErrW-2:2];
      end
      ctx3_in.sgn_neg = err_ff[0][ErrW-1];
      for (int i = 0; i < 3; i++) begin
         ctx3_in.vec_neg[i] = err_ff[i+1][ErrW-1];
      end
   end

   // Stage 4: squares.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         sq_in[i] = mag_ff[i] * mag_ff[i];
      end
   end

   // Stage 5: sum of squares.
   always_comb begin
      sum_in = SumW'(sq_ff[0]) + SumW'(sq_ff[1]) + SumW'(sq_ff[2]) + SumW'(sq_ff[3]);
      side5_in.ctx = ctx4_ff;
      side5_in.mag = mag4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
      prod_ff  <= prod_in;
      ctx1_ff  <= ctx1_in;
      err_ff   <= err_in;
      ctx2_ff  <= ctx1_ff;
      mag_ff   <= mag_in;
      ctx3_ff  <= ctx3_in;
      sq_ff    <= sq_in;
      ctx4_ff  <= ctx3_ff;
      for (int i = 0; i < 3; i++) begin
         mag4_ff[i] <= mag_ff[i+1];
      end
      sum_ff   <= sum_in;
      side5_ff <= side5_in;
   end

   assign out_valid  = v5_ff;
   assign out_sum[0] = sum_ff;
   assign out_side   = side5_ff;

endmodule

`default_nettype wire

@@ rtl/qapm_mix.sv @@
`default_nettype none

module qapm_mix (
   input  logic                                     clock,
   input  logic                                     reset,
   input  qapm_pkg::cfg_type                        cfg,
   input  logic                                     in_valid,
   input  logic [2:0][qapm_pkg::NvW-1:0]            in_quot,
   input  qapm_pkg::ctx_type                        in_ctx,
   output logic                                     out_valid,
   output logic [3:0][qapm_pkg::SpeedSqW-1:0]       out_speed_sq,
   output logic [3:0]                               out_flags
);

   import qapm_pkg::*;

   localparam int KpProdW = 17 + NvW + 1;
   localparam int KdProdW = 17 + RateErrW;
   localparam int T26W    = KdProdW + 4;
   localparam int ArmW    = TauW + 17;
   localparam int PpW     = ArmW + 18;
   localparam int HiW     = (ForceW - 17) + 32;
   localparam int LoW     = 16 + 32;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;
   logic [15:0] thr1_ff, thr2_ff, thr3_ff, thr4_ff;

   logic signed [KpProdW-1:0] pkp_ff [3];
   logic signed [KpProdW-1:0] pkp_in [3];
   logic signed [KdProdW-1:0] pkd_ff [3];
   logic signed [KdProdW-1:0] pkd_in [3];
   logic signed [TauW-1:0]    tau_ff [3];
   logic signed [TauW-1:0]    tau_in [3];
   logic signed [ArmW-1:0]    tr_ff [2];
   logic signed [ArmW-1:0]    tr_in [2];
   logic signed [ArmW-1:0]    az_ff, az_in, az4_ff;
   logic signed [ArmW-1:0]    tr4_ff [2];
   logic signed [PpW-1:0]     pp_ff [2];
   logic signed [PpW-1:0]     pp_in [2];
   logic signed [ForceW-1:0]  f_ff [4];
   logic signed [ForceW-1:0]  f_in [4];
   logic [HiW-1:0]            hi_ff [4];
   logic [HiW-1:0]            hi_in [4];
   logic [LoW-1:0]            lo_ff [4];
   logic [LoW-1:0]            lo_in [4];
   logic [3:0]                flag6_ff, flag6_in, flag7_ff;
   logic [3:0][SpeedSqW-1:0]  w2_ff, w2_in;

   // Stage 1: signed proportional and rate products per axis.
   always_comb begin
      logic signed [NvW:0] snv;
      for (int i = 0; i < 3; i++) begin
         snv = (in_ctx.sgn_neg ^ in_ctx.vec_neg[i]) ? -$signed({1'b0, in_quot[i]})
                                                    : $signed({1'b0, in_quot[i]});
         pkp_in[i] = $signed({1'b0, cfg.kp[16*i +: 16]}) * snv;
         pkd_in[i] = $signed({1'b0, cfg.kd[16*i +: 16]}) * $signed(in_ctx.rate_err[i]);
      end
   end

   // Stage 2: torque sum, round half up to Q.16, deadband.
   always_comb begin
      logic signed [T26W-1:0] t26;
      logic signed [TauW-1:0] t;
      logic [TauW-1:0]        t_mag;
      for (int i = 0; i < 3; i++) begin
         t26       = T26W'(pkp_ff[i]) + (T26W'(pkd_ff[i]) <<< 4) + T26W'(512);
         t         = t26[T26W-1:10];
         t_mag     = t[TauW-1] ? -t : t;
         tau_in[i] = (t_mag < TauW'(cfg.deadband)) ? '0 : t;
      end
   end

   // Stage 3: scale by arm and yaw reciprocals.
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         tr_in[i] = tau_ff[i] * $signed({1'b0, cfg.arm_recip});
      end
      az_in = tau_ff[2] * $signed({1'b0, cfg.yaw_recip});
   end

   // Stage 4: sqrt(2) products for the X frame.
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         pp_in[i] = tr_ff[i] * $signed({1'b0, Sqrt2Q16});
      end
   end

   // Stage 5: closed-form mixing into four forces.
   always_comb begin
      logic signed [ForceW-1:0] tq, ax, ay, az, px, py;
      logic signed [PpW-1:0]    rnd0, rnd1;
      tq   = $signed({16'b0, thr4_ff, 16'b0});
      ax   = ForceW'(tr4_ff[0]) <<< 1;
      ay   = ForceW'(tr4_ff[1]) <<< 1;
      az   = ForceW'(az4_ff);
      rnd0 = pp_ff[0] + PpW'(32768);
      rnd1 = pp_ff[1] + PpW'(32768);
      px   = ForceW'(rnd0 >>> 16);
      py   = ForceW'(rnd1 >>> 16);
      unique case (cfg.frame)
         FRAME_PLUS: begin
            f_in[0] = tq - ay + az;
            f_in[1] = tq - ax - az;
            f_in[2] = tq + ay + az;
            f_in[3] = tq + ax - az;
         end
         FRAME_X: begin
            f_in[0] = tq + px - py + az;
            f_in[1] = tq - px - py - az;
            f_in[2] = tq - px + py + az;
            f_in[3] = tq + px + py - az;
         end
      endcase
   end

   // Stage 6: clamp negative forces and split the thrust scaling product.
   always_comb begin
      logic [ForceW-2:0] fu;
      for (int i = 0; i < 4; i++) begin
         flag6_in[i] = f_ff[i][ForceW-1];
         fu          = f_ff[i][ForceW-1] ? '0 : f_ff[i][ForceW-2:0];
         hi_in[i]    = fu[ForceW-2:16] * cfg.thrust_recip;
         lo_in[i]    = fu[15:0] * cfg.thrust_recip;
      end
   end

   // Stage 7: speed squared in Q.8.
   always_comb begin
      logic [63:0] acc;
      for (int i = 0; i < 4; i++) begin
         acc      = 64'(hi_ff[i]) + 64'(lo_ff[i] >> 16);
         w2_in[i] = acc[63:18];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
      thr1_ff  <= in_ctx.thrust;
      thr2_ff  <= thr1_ff;
      thr3_ff  <= thr2_ff;
      thr4_ff  <= thr3_ff;
      pkp_ff   <= pkp_in;
      pkd_ff   <= pkd_in;
      tau_ff   <= tau_in;
      tr_ff    <= tr_in;
      az_ff    <= az_in;
      pp_ff    <= pp_in;
      tr4_ff   <= tr_ff;
      az4_ff   <= az_ff;
      f_ff     <= f_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      flag6_ff <= flag6_in;
      flag7_ff <= flag6_ff;
      w2_ff    <= w2_in;
   end

   assign out_valid    = v7_ff;
   assign out_speed_sq = w2_ff;
   assign out_flags    = flag7_ff;

endmodule

`default_nettype wire

@@ rtl/quaternion_attitude_pd_mixer.sv @@
`default_nettype none

// Quaternion PD attitude controller with quadrotor motor mixer.
//
// Request channel: a beat is taken on each rising edge with start high and
// busy low. busy stays low, so a new beat may be issued every cycle.
// Response channel: rsp_strobe is high for one cycle with rsp_payload
// holding four motor speeds and the clamp flags. The receiver cannot stall.
// Configuration channel: csr_valid/csr_ready write csr_data to the register
// selected by csr_index; csr_ready is always high. Write only while idle.
//
// Throughput is one beat per cycle. From the accepting edge to the result, a
// beat passes the 32-stage norm square root, the 15-stage divider, the
// 23-stage speed square root and 13 arithmetic stages around them.
//
// Reset (synchronous, active high) clears all in-flight beats and returns
// the registers to their default gains and frame settings.
module quaternion_attitude_pd_mixer (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  qapm_pkg::req_type                     req_payload,
   output logic                                  rsp_strobe,
   output qapm_pkg::rsp_type                     rsp_payload,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [qapm_pkg::CsrIndexW-1:0]        csr_index,
   input  logic [qapm_pkg::CsrDataW-1:0]         csr_data
);

   import qapm_pkg::*;

   localparam int NormSideW     = $bits(sqrt_side_type);
   localparam int CtxW          = $bits(ctx_type);
   localparam int LatencyCycles = 83;

   cfg_type                   cfg_ff, cfg_in;
   logic                      accept;
   logic                      err_valid;
   logic [0:0][SumW-1:0]      err_sum;
   sqrt_side_type             err_side;
   logic                      norm_valid;
   logic [0:0][NormW-1:0]     norm_root;
   sqrt_side_type             norm_side;
   logic                      div_valid;
   logic [2:0][NvW-1:0]       div_quot;
   ctx_type                   div_ctx;
   logic                      mix_valid;
   logic [3:0][SpeedSqW-1:0]  mix_sq;
   logic [3:0]                mix_flags;
   logic                      spd_valid;
   logic [3:0][RootW-1:0]     spd_root;
   logic [3:0]                spd_flags;
   logic                      strobe_ff;
   rsp_type                   rsp_ff, rsp_in;

   // The pipeline never backs up, so a beat is taken in every cycle that start is high.
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start & ~busy;

   // Configuration register file.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_KP:       cfg_in.kp           = csr_data;
            CSR_KD:       cfg_in.kd           = csr_data;
            CSR_FLIGHT:   cfg_in.frame        = frame_type'(csr_data[0]);
            CSR_ARM:      cfg_in.arm_recip    = csr_data[15:0];
            CSR_YAW:      cfg_in.yaw_recip    = csr_data[15:0];
            CSR_THRUST:   cfg_in.thrust_recip = csr_data[31:0];
            CSR_DEADBAND: cfg_in.deadband     = csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CfgReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Error quaternion and its sum of squares.
   qapm_err u_err (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_req    (req_payload),
      .out_valid (err_valid),
      .out_sum   (err_sum),
      .out_side  (err_side)
   );

   // Norm of the error quaternion.
   qapm_isqrt #(
      .InW   (SumW),
      .Lanes (1),
      .SideW (NormSideW)
   ) u_norm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (err_valid),
      .in_value  (err_sum),
      .in_side   (err_side),
      .out_valid (norm_valid),
      .out_root  (norm_root),
      .out_side  (norm_side)
   );

   // Normalize the vector part.
   qapm_div #(
      .QuotW (NvW),
      .NumW  (MagW),
      .DenW  (NormW),
      .Lanes (3),
      .SideW (CtxW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (norm_valid),
      .in_num    (norm_side.mag),
      .in_den    (norm_root[0]),
      .in_side   (norm_side.ctx),
      .out_valid (div_valid),
      .out_quot  (div_quot),
      .out_side  (div_ctx)
   );

   // Torques, mixing and thrust scaling.
   qapm_mix u_mix (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .in_valid     (div_valid),
      .in_quot      (div_quot),
      .in_ctx       (div_ctx),
      .out_valid    (mix_valid),
      .out_speed_sq (mix_sq),
      .out_flags    (mix_flags)
   );

   // Motor speeds from speed squared.
   qapm_isqrt #(
      .InW   (SpeedSqW),
      .Lanes (4),
      .SideW (4)
   ) u_speed (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mix_valid),
      .in_value  (mix_sq),
      .in_side   (mix_flags),
      .out_valid (spd_valid),
      .out_root  (spd_root),
      .out_side  (spd_flags)
   );

   // Saturate speeds and register the response beat.
   always_comb begin
      logic [3:0][SpeedW-1:0] sat;
      for (int i = 0; i < 4; i++) begin
         sat[i] = (spd_root[i][RootW-1:SpeedW] != '0) ? '1 : spd_root[i][SpeedW-1:0];
      end
      rsp_in.motor_speed_0 = sat[0];
      rsp_in.motor_speed_1 = sat[1];
      rsp_in.motor_speed_2 = sat[2];
      rsp_in.motor_speed_3 = sat[3];
      rsp_in.clamp_flags   = spd_flags;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= spd_valid;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_payload = rsp_ff;

   // Every response beat comes from a request taken a fixed time earlier.
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, LatencyCycles))
      else $error("response beat without a matching request");

   // Every request taken produces a response beat after the fixed latency.
   a_req_gets_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LatencyCycles rsp_strobe)
      else $error("request beat lost in the pipeline");

   // A clamped motor always commands zero speed.
   a_clamp_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |->
         ((!rsp_payload.clamp_flags[0] || (rsp_payload.motor_speed_0 == '0)) &&
          (!rsp_payload.clamp_flags[1] || (rsp_payload.motor_speed_1 == '0)) &&
          (!rsp_payload.clamp_flags[2] || (rsp_payload.motor_speed_2 == '0)) &&
          (!rsp_payload.clamp_flags[3] || (rsp_payload.motor_speed_3 == '0))))
      else $error("clamped motor with nonzero speed");

endmodule

`default_nettype wire
